// File: src/bqf_pkg.sv
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared widths and register indexes for the Q14 direct form I biquad.
// ----------------------------------------------------------------------------
package bqf_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 16;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   // five rounded products need three guard bits
   localparam int SUM_W     = PROD_W + 3;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_B0 = 3'd0,
      CSR_COEF_B1 = 3'd1,
      CSR_COEF_B2 = 3'd2,
      CSR_COEF_A1 = 3'd3,
      CSR_COEF_A2 = 3'd4
   } csr_index_type;

endpackage

// File: src/biquad_q14_filter_core.sv
// ----------------------------------------------------------------------------
// biquad_q14_filter_core
// Direct form I biquad on 16-bit signed samples with five programmable
// fixed-point coefficients, per-product rounding and a wrapped 16-bit output.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake           payload
//   req_      in          req_valid/stall     req_sample_in, req_block_end
//   rsp_      out         rsp_valid/stall     rsp_sample_out, rsp_wrapped,
//                                             rsp_block_end_out
//   csr_      in          csr_valid/ready     csr_index, csr_wdata
//
// One sample per cycle sustained while rsp_stall is low; a request reaches
// rsp_valid through the input register, then the result register.
// The feedback path, five parallel 16x16 multiplies and a five-term sum from
// the input register to the result register, sets the clock limit.
// Reset clears coefficients, sample history and both valid flags.
// A stalled response keeps its value; one more request is held in the input
// register, after which req_stall rises until the response transfers.
// ----------------------------------------------------------------------------
module biquad_q14_filter_core #(
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [bqf_pkg::SAMPLE_W-1:0]    req_sample_in,
   input  logic                                   req_block_end,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [bqf_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   output logic                                   rsp_wrapped,
   output logic                                   rsp_block_end_out,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bqf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [bqf_pkg::COEF_W-1:0]             csr_wdata
);

   localparam int SW = bqf_pkg::SAMPLE_W;
   localparam int CW = bqf_pkg::COEF_W;
   localparam int PW = bqf_pkg::PROD_W;
   localparam int TW = bqf_pkg::SUM_W;
   localparam logic signed [PW-1:0] ROUND_HALF = PW'(64'sd1 <<< (COEF_FRAC_BITS - 1));

   // coefficients
   logic signed [CW-1:0] coef_b0_ff, coef_b1_ff, coef_b2_ff, coef_a1_ff, coef_a2_ff;

   // input register
   logic                 stg_valid_ff, stg_valid_in;
   logic signed [SW-1:0] stg_sample_ff, stg_sample_in;
   logic                 stg_last_ff, stg_last_in;

   // history
   logic signed [SW-1:0] x1_ff, x1_in, x2_ff, x2_in;
   logic signed [SW-1:0] y1_ff, y1_in, y2_ff, y2_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic signed [SW-1:0] out_sample_ff, out_sample_in;
   logic                 out_wrap_ff, out_wrap_in;
   logic                 out_last_ff, out_last_in;

   logic                 req_xfer, advance;
   logic signed [PW-1:0] prod_b0, prod_b1, prod_b2, prod_a1, prod_a2;
   logic signed [PW-1:0] rnd_b0, rnd_b1, rnd_b2, rnd_a1, rnd_a2;
   logic signed [TW-1:0] acc;
   logic signed [SW-1:0] acc_wrap;

   assign csr_ready = 1'b1;

   // result register is free when empty or being drained this cycle
   assign advance   = stg_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = stg_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      prod_b0 = coef_b0_ff * stg_sample_ff;
      prod_b1 = coef_b1_ff * x1_ff;
      prod_b2 = coef_b2_ff * x2_ff;
      prod_a1 = coef_a1_ff * y1_ff;
      prod_a2 = coef_a2_ff * y2_ff;

      rnd_b0 = (prod_b0 + ROUND_HALF) >>> COEF_FRAC_BITS;
      rnd_b1 = (prod_b1 + ROUND_HALF) >>> COEF_FRAC_BITS;
      rnd_b2 = (prod_b2 + ROUND_HALF) >>> COEF_FRAC_BITS;
      rnd_a1 = (prod_a1 + ROUND_HALF) >>> COEF_FRAC_BITS;
      rnd_a2 = (prod_a2 + ROUND_HALF) >>> COEF_FRAC_BITS;

      acc = TW'(rnd_b0) + TW'(rnd_b1) + TW'(rnd_b2) - TW'(rnd_a1) - TW'(rnd_a2);
      acc_wrap = acc[SW-1:0];
   end

   always_comb begin
      stg_valid_in  = stg_valid_ff;
      stg_sample_in = stg_sample_ff;
      stg_last_in   = stg_last_ff;
      x1_in = x1_ff;
      x2_in = x2_ff;
      y1_in = y1_ff;
      y2_in = y2_ff;
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      out_wrap_in   = out_wrap_ff;
      out_last_in   = out_last_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         stg_valid_in  = 1'b0;
         out_valid_in  = 1'b1;
         out_sample_in = acc_wrap;
         out_wrap_in   = (TW'(acc_wrap) != acc);
         out_last_in   = stg_last_ff;
         x1_in = stg_sample_ff;
         x2_in = x1_ff;
         y1_in = acc_wrap;
         y2_in = y1_ff;
      end
      if (req_xfer) begin
         stg_valid_in  = 1'b1;
         stg_sample_in = req_sample_in;
         stg_last_in   = req_block_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
         x1_ff <= x1_in;
         x2_ff <= x2_in;
         y1_ff <= y1_in;
         y2_ff <= y2_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_sample_ff <= stg_sample_in;
      stg_last_ff   <= stg_last_in;
      out_sample_ff <= out_sample_in;
      out_wrap_ff   <= out_wrap_in;
      out_last_ff   <= out_last_in;
   end

   // register file, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= '0;
         coef_b1_ff <= '0;
         coef_b2_ff <= '0;
         coef_a1_ff <= '0;
         coef_a2_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bqf_pkg::CSR_COEF_B0: coef_b0_ff <= csr_wdata;
            bqf_pkg::CSR_COEF_B1: coef_b1_ff <= csr_wdata;
            bqf_pkg::CSR_COEF_B2: coef_b2_ff <= csr_wdata;
            bqf_pkg::CSR_COEF_A1: coef_a1_ff <= csr_wdata;
            bqf_pkg::CSR_COEF_A2: coef_a2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_sample_out    = out_sample_ff;
   assign rsp_wrapped       = out_wrap_ff;
   assign rsp_block_end_out = out_last_ff;

endmodule

// File: tb/sv/biquad_q14_filter_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_q14_filter_core_checker
// Follows coefficient writes and sample transfers, runs its own direct form I
// biquad with per-product rounding and 16-bit wrap, and compares every
// response transfer with the oldest predicted sample.
// ----------------------------------------------------------------------------
module biquad_q14_filter_core_checker #(
   parameter int FRAC_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [bqf_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                req_block_end,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [bqf_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                rsp_wrapped,
   input  logic                                rsp_block_end_out,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [bqf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bqf_pkg::COEF_W-1:0]          csr_wdata,
   output int                                  fail_count,
   output int                                  pending
);

   localparam int SW = bqf_pkg::SAMPLE_W;
   localparam int CW = bqf_pkg::COEF_W;

   typedef struct packed {
      logic signed [SW-1:0] sample_out;
      logic                 wrapped;
      logic                 block_end_out;
   } filter_result_type;

   filter_result_type filtered_q[$];

   logic signed [CW-1:0] b0, b1, b2, a1, a2;
   logic signed [SW-1:0] x1, x2, y1, y2;

   function automatic longint rounded_product(input logic signed [CW-1:0] c,
                                              input logic signed [SW-1:0] d);
      longint p;
      p = longint'(c) * longint'(d) + (longint'(1) << (FRAC_BITS - 1));
      return p >>> FRAC_BITS;
   endfunction

   // advances the filter history by one sample and returns what it produces
   function automatic filter_result_type filter_sample(input logic signed [SW-1:0] x,
                                                       input logic be);
      longint               acc;
      logic signed [SW-1:0] y;
      filter_result_type    r;
      acc = rounded_product(b0, x) + rounded_product(b1, x1) + rounded_product(b2, x2)
          - rounded_product(a1, y1) - rounded_product(a2, y2);
      y               = acc[SW-1:0];
      r.sample_out    = y;
      r.wrapped       = (longint'(y) != acc);
      r.block_end_out = be;
      x2 = x1;
      x1 = x;
      y2 = y1;
      y1 = y;
      return r;
   endfunction

   always @(posedge clock) begin
      filter_result_type want;
      if (reset) begin
         b0 = '0; b1 = '0; b2 = '0; a1 = '0; a2 = '0;
         x1 = '0; x2 = '0; y1 = '0; y2 = '0;
         filtered_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bqf_pkg::CSR_COEF_B0: b0 = csr_wdata;
               bqf_pkg::CSR_COEF_B1: b1 = csr_wdata;
               bqf_pkg::CSR_COEF_B2: b2 = csr_wdata;
               bqf_pkg::CSR_COEF_A1: a1 = csr_wdata;
               bqf_pkg::CSR_COEF_A2: a2 = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (filtered_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with nothing outstanding: %s=%0d %s=%b %s=%b",
                           $realtime, "out", rsp_sample_out, "wrapped", rsp_wrapped,
                           "end", rsp_block_end_out);
            end else begin
               want = filtered_q.pop_front();
               if (rsp_sample_out !== want.sample_out || rsp_wrapped !== want.wrapped ||
                   rsp_block_end_out !== want.block_end_out) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch: expected out=%0d wrapped=%b end=%b, ",
                               "got out=%0d wrapped=%b end=%b"},
                              $realtime, $signed(want.sample_out), want.wrapped,
                              want.block_end_out,
                              rsp_sample_out, rsp_wrapped, rsp_block_end_out);
               end
            end
         end
         if (req_valid && !req_stall)
            filtered_q.push_back(filter_sample(req_sample_in, req_block_end));
      end
      pending = filtered_q.size();
   end

endmodule

// File: tb/sv/biquad_q14_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_q14_filter_core_tb
// Drives coefficient sets and sample streams into the biquad core with random
// gaps and response back-pressure; the checker beside the core predicts and
// compares every response, and this top gives the verdict.
// ----------------------------------------------------------------------------
module biquad_q14_filter_core_tb;

   localparam int FRAC_BITS  = 14;
   localparam int IDLE_LIMIT = 2000;
   localparam int SW = bqf_pkg::SAMPLE_W;
   localparam int IW = bqf_pkg::CSR_IDX_W;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SW-1:0]       req_sample_in = '0;
   logic                       req_block_end = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SW-1:0]       rsp_sample_out;
   logic                       rsp_wrapped;
   logic                       rsp_block_end_out;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [IW-1:0]              csr_index = '0;
   logic [bqf_pkg::COEF_W-1:0] csr_wdata = '0;

   int   fail_count;
   int   pending;
   int   quiet_cycles = 0;
   logic calm = 1'b0;

   biquad_q14_filter_core #(.COEF_FRAC_BITS(FRAC_BITS)) dut (.*);

   biquad_q14_filter_core_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 19);

   // watchdog on cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("biquad_q14_filter_core verification failed");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   function automatic logic [15:0] pick_sample();
      logic [15:0] v;
      case ($urandom_range(9))
         0: case ($urandom_range(3))
               0: v = 16'h8000;
               1: v = 16'h7fff;
               2: v = 16'h0000;
               default: v = 16'hffff;
            endcase
         1, 2: v = 16'($urandom_range(511)) - 16'd256;
         default: v = 16'($urandom_range(65535));
      endcase
      return v;
   endfunction

   function automatic logic [15:0] pick_coef();
      logic [15:0] v;
      case ($urandom_range(3))
         0: case ($urandom_range(3))
               0: v = 16'h8000;
               1: v = 16'h7fff;
               2: v = 16'h0000;
               default: v = 16'hffff;
            endcase
         1: v = 16'($urandom_range(32767)) - 16'd16384;
         default: v = 16'($urandom_range(65535));
      endcase
      return v;
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_sample(input logic [15:0] s, input logic be);
      if (!calm)
         while ($urandom_range(99) < 19) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      req_block_end <= be;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // hold the sender off until every predicted sample has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic write_coef(input logic [IW-1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic load_coefs(input logic [15:0] c0, c1, c2, c3, c4);
      drain();
      repeat (4) @(negedge clock);
      write_coef(bqf_pkg::CSR_COEF_B0, c0);
      write_coef(bqf_pkg::CSR_COEF_B1, c1);
      write_coef(bqf_pkg::CSR_COEF_B2, c2);
      write_coef(bqf_pkg::CSR_COEF_A1, c3);
      write_coef(bqf_pkg::CSR_COEF_A2, c4);
      // indexes past the last register must leave the set untouched
      write_coef(IW'($urandom_range(2 ** IW - 1, bqf_pkg::CSR_COEF_A2 + 1)),
                 16'($urandom_range(65535)));
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // coefficients still at reset: all zero out
      send_sample(16'h7fff, 1'b0);
      send_sample(16'h8000, 1'b1);

      // unity gain on the current sample
      load_coefs(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h7fff, 1'b0);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hffff, 1'b1);
      send_sample(16'h0001, 1'b0);

      // largest positive everywhere, sums wrap
      load_coefs(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_sample(16'h7fff, 1'b0);
      send_sample(16'h7fff, 1'b0);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h8000, 1'b0);

      // most negative everywhere, feedback subtracts a negative
      load_coefs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7fff, 1'b1);
      send_sample(16'hffff, 1'b0);

      // history carries across block ends
      load_coefs(16'h0400, 16'h0800, 16'h0400, 16'h9c40, 16'h2710);
      send_sample(16'h2000, 1'b1);
      send_sample(16'h0000, 1'b1);
      send_sample(16'h0000, 1'b0);

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: load_coefs(pick_coef(), pick_coef(), pick_coef(), 16'h0000, 16'h0000);
            1: load_coefs(16'h0200, 16'h0400, 16'h0200, 16'h8a00, 16'h3200);
            default: load_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                                pick_coef());
         endcase
         calm = (phase == 3);
         for (int n = 0; n < 200; n++) begin
            if (n == 100)
               drain();
            send_sample(pick_sample(), $urandom_range(15) == 0);
         end
      end
      calm = 1'b0;

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("biquad_q14_filter_core verification clean");
      else
         $display("biquad_q14_filter_core verification failed");
      $finish;
   end

endmodule
